[design/tree_kth_ancestor_lookup_core_macros.svh]
// Assertion macros for the k-th ancestor lookup core.
// Included by the top level; no other dependencies.
`ifndef TREE_KTH_ANCESTOR_LOOKUP_CORE_MACROS_SVH
`define TREE_KTH_ANCESTOR_LOOKUP_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold in the same cycle as the condition.
`define TKA_ASSERT_NOW(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// Property must hold in the cycle after the condition.
`define TKA_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define TKA_ASSERT_NOW(lbl, clk, rst_n, cond, prop, msg)
`define TKA_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg)
`endif
`endif

[design/tka_pkg.sv]
// Shared types, op codes and helper functions for the k-th ancestor lookup core.
// No dependencies.
`timescale 1ns / 1ps

package tka_pkg;

    // Fixed field widths.
    localparam int NODE_W = 10;
    localparam int OP_W   = 2;
    localparam int HB_W   = 4;

    // Item op codes.
    typedef logic [OP_W-1:0] op_t;
    localparam op_t OP_SET_PARENT = 2'd0;
    localparam op_t OP_BUILD      = 2'd1;
    localparam op_t OP_QUERY      = 2'd2;

    // Result handed from the sequencer to the output register.
    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] ancestor;
        logic              is_answer;
    } tka_result_t;

    // Position of the highest set bit; zero for inputs of zero or one.
    function automatic logic [HB_W-1:0] high_bit(input logic [NODE_W-1:0] x);
        logic [HB_W-1:0] b;
        b = '0;
        for (int i = 1; i < NODE_W; i++) begin
            if (x[i])
            begin
                b = HB_W'(i);
            end
        end
        return b;
    endfunction

endpackage

[design/tka_jump_ram.sv]
// Jump table storage: one write port and one registered read port.
// Depends on tka_pkg for the entry width.
`timescale 1ns / 1ps

module tka_jump_ram #(
    parameter int AW = 14
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [tka_pkg::NODE_W-1:0] wdata,
    input  logic [AW-1:0]              raddr,
    output logic [tka_pkg::NODE_W-1:0] rdata
);
    import tka_pkg::*;

    logic [NODE_W-1:0] mem [1 << AW];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[design/tka_seq.sv]
// Sequencer that clears the table, writes parents, builds jump levels and walks queries.
// Depends on tka_pkg; drives the tka_jump_ram ports.
`timescale 1ns / 1ps

module tka_seq #(
    parameter int MAX_NODES   = 1024,
    parameter int JUMP_LEVELS = 10,
    parameter int AW          = 14
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_fire,
    input  tka_pkg::op_t               op,
    input  logic [tka_pkg::NODE_W-1:0] node,
    input  logic [tka_pkg::NODE_W-1:0] value,
    input  logic [tka_pkg::NODE_W-1:0] node_count,
    input  logic                       slot_free,
    output logic                       idle,
    output logic                       mem_we,
    output logic [AW-1:0]              mem_waddr,
    output logic [tka_pkg::NODE_W-1:0] mem_wdata,
    output logic [AW-1:0]              mem_raddr,
    input  logic [tka_pkg::NODE_W-1:0] mem_rdata,
    output tka_pkg::tka_result_t       res
);
    import tka_pkg::*;

    localparam int NW = $clog2(MAX_NODES);
    localparam int LW = (JUMP_LEVELS > 1) ? $clog2(JUMP_LEVELS) : 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_QUERY,
        S_BUILD_A,
        S_BUILD_B,
        S_BUILD_W,
        S_FINISH
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [NODE_W-1:0] k_reg, k_next;
    logic [NODE_W-1:0] cur_reg, cur_next;
    logic              pend_reg, pend_next;
    logic [LW-1:0]     lvl_reg, lvl_next;
    logic [LW-1:0]     top_reg, top_next;
    logic [NW-1:0]     n_reg, n_next;
    logic [NW-1:0]     last_reg, last_next;
    logic [NODE_W-1:0] ans_reg, ans_next;
    logic              is_ans_reg, is_ans_next;

    logic [NODE_W-1:0] cur_now;
    logic [LW-1:0]     q_lvl;
    logic [LW-1:0]     lvl_below;
    logic [LW-1:0]     build_top;
    logic              node_ok;

    // Row of the table for a node number; out-of-range nodes map to the empty row 0.
    function automatic logic [NW-1:0] row_of(input logic [NODE_W-1:0] n);
        return (32'(n) < MAX_NODES) ? NW'(n) : '0;
    endfunction

    // Clamp a bit position to the top jump level.
    function automatic logic [LW-1:0] cap_lvl(input logic [HB_W-1:0] b);
        return (32'(b) > JUMP_LEVELS - 1) ? LW'(JUMP_LEVELS - 1) : LW'(b);
    endfunction

    assign node_ok   = (node != '0) && (32'(node) < MAX_NODES);
    assign cur_now   = pend_reg ? mem_rdata : cur_reg;
    assign q_lvl     = cap_lvl(high_bit(k_reg));
    assign lvl_below = LW'(lvl_reg - LW'(1));
    assign build_top = cap_lvl(high_bit(node_count));

    assign idle          = (state_reg == S_IDLE);
    assign res.valid     = (state_reg == S_FINISH);
    assign res.ancestor  = ans_reg;
    assign res.is_answer = is_ans_reg;

    // Next-state and table access logic.
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        k_next       = k_reg;
        cur_next     = cur_reg;
        pend_next    = pend_reg;
        lvl_next     = lvl_reg;
        top_next     = top_reg;
        n_next       = n_reg;
        last_next    = last_reg;
        ans_next     = ans_reg;
        is_ans_next  = is_ans_reg;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_raddr    = '0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                clr_cnt_next = AW'(clr_cnt_reg + AW'(1));
                if (&clr_cnt_reg)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_fire)
                begin
                    ans_next    = '0;
                    is_ans_next = 1'b0;
                    state_next  = S_FINISH;
                    case (op)
                        OP_SET_PARENT:
                        begin
                            mem_we    = node_ok;
                            mem_waddr = {NW'(node), LW'(0)};
                            mem_wdata = value;
                        end
                        OP_BUILD:
                        begin
                            top_next  = build_top;
                            last_next = (32'(node_count) > MAX_NODES - 1) ?
                                        NW'(MAX_NODES - 1) : NW'(node_count);
                            lvl_next  = LW'(1);
                            n_next    = NW'(1);
                            if ((node_count != '0) && (build_top != '0))
                            begin
                                state_next = S_BUILD_A;
                            end
                        end
                        OP_QUERY:
                        begin
                            cur_next   = (32'(node) < MAX_NODES) ? node : '0;
                            k_next     = value;
                            pend_next  = 1'b0;
                            state_next = S_QUERY;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            // One jump per cycle; the read issued here lands in the next cycle.
            S_QUERY:
            begin
                cur_next = cur_now;
                if (k_reg == '0)
                begin
                    ans_next    = cur_now;
                    is_ans_next = 1'b1;
                    pend_next   = 1'b0;
                    state_next  = S_FINISH;
                end
                else
                begin
                    mem_raddr = {row_of(cur_now), q_lvl};
                    k_next    = NODE_W'(k_reg - (NODE_W'(1) << q_lvl));
                    pend_next = 1'b1;
                end
            end

            // Read the node's entry one level down.
            S_BUILD_A:
            begin
                mem_raddr  = {n_reg, lvl_below};
                state_next = S_BUILD_B;
            end

            // Read that ancestor's entry at the same level.
            S_BUILD_B:
            begin
                mem_raddr  = {row_of(mem_rdata), lvl_below};
                state_next = S_BUILD_W;
            end

            // Store the doubled jump and step to the next node or level.
            S_BUILD_W:
            begin
                mem_we     = 1'b1;
                mem_waddr  = {n_reg, lvl_reg};
                mem_wdata  = mem_rdata;
                state_next = S_BUILD_A;
                if (n_reg == last_reg)
                begin
                    n_next = NW'(1);
                    if (lvl_reg == top_reg)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        lvl_next = LW'(lvl_reg + LW'(1));
                    end
                end
                else
                begin
                    n_next = NW'(n_reg + NW'(1));
                end
            end

            S_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            pend_reg    <= 1'b0;
            k_reg       <= '0;
            cur_reg     <= '0;
            lvl_reg     <= '0;
            top_reg     <= '0;
            n_reg       <= '0;
            last_reg    <= '0;
            ans_reg     <= '0;
            is_ans_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            pend_reg    <= pend_next;
            k_reg       <= k_next;
            cur_reg     <= cur_next;
            lvl_reg     <= lvl_next;
            top_reg     <= top_next;
            n_reg       <= n_next;
            last_reg    <= last_next;
            ans_reg     <= ans_next;
            is_ans_reg  <= is_ans_next;
        end
    end

endmodule

[design/tree_kth_ancestor_lookup_core.sv]
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  input   | in_valid, in_stall, op, node, value      | in, stall out
//  output  | out_valid, out_stall, ancestor, is_answer| out, stall in
//  config  | cfg_wr_en, cfg_wr_data (node_count)      | in
//
// After reset the table is swept to zero, one entry a cycle, over all 2^AW table entries
// (16384 by default); in_stall is high.
// A query reads the table once per jump, and a build reads it twice and writes it once
// per table entry built; all reads share the single table read port.
// One item is worked at a time; the result waits in an output register while the next is taken.
// Configuration writes are taken at any time and should be made while the block is idle.
`timescale 1ns / 1ps

`include "tree_kth_ancestor_lookup_core_macros.svh"

module tree_kth_ancestor_lookup_core #(
    parameter int MAX_NODES   = 1024,
    parameter int JUMP_LEVELS = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  tka_pkg::op_t               op,
    input  logic [tka_pkg::NODE_W-1:0] node,
    input  logic [tka_pkg::NODE_W-1:0] value,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [tka_pkg::NODE_W-1:0] ancestor,
    output logic                       is_answer,
    input  logic                       cfg_wr_en,
    input  logic [tka_pkg::NODE_W-1:0] cfg_wr_data
);
    import tka_pkg::*;

    localparam int NW = $clog2(MAX_NODES);
    localparam int LW = (JUMP_LEVELS > 1) ? $clog2(JUMP_LEVELS) : 1;
    localparam int AW = NW + LW;
    localparam logic [NODE_W-1:0] NODE_COUNT_RESET = 10'd1023;

    logic [NODE_W-1:0] node_count_reg;
    logic              out_valid_reg, out_valid_next;
    logic [NODE_W-1:0] ancestor_reg;
    logic              is_answer_reg;

    logic              in_fire;
    logic              idle;
    logic              slot_free;
    logic              load;
    tka_result_t       seq_res;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [NODE_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [NODE_W-1:0] mem_rdata;

    assign in_stall  = !idle;
    assign in_fire   = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign load      = seq_res.valid && slot_free;

    assign out_valid = out_valid_reg;
    assign ancestor  = ancestor_reg;
    assign is_answer = is_answer_reg;

    tka_seq #(
        .MAX_NODES   (MAX_NODES),
        .JUMP_LEVELS (JUMP_LEVELS),
        .AW          (AW)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .op         (op),
        .node       (node),
        .value      (value),
        .node_count (node_count_reg),
        .slot_free  (slot_free),
        .idle       (idle),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata),
        .res        (seq_res)
    );

    tka_jump_ram #(
        .AW (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Output valid holds while stalled and sets when a result is loaded.
    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    // Configuration register and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                node_count_reg <= cfg_wr_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload, loaded only when the slot is free.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ancestor_reg  <= seq_res.ancestor;
            is_answer_reg <= seq_res.is_answer;
        end
    end

    // Checks on the sequencer and output stage.
    `TKA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, in_stall,
        "block took a second item while busy")
    `TKA_ASSERT_NOW(a_non_answer_zero, clk, rst_n, out_valid && !is_answer, ancestor == '0,
        "non-query item gave a nonzero ancestor")
    `TKA_ASSERT_NEXT(a_result_held, clk, rst_n, seq_res.valid && !slot_free,
        seq_res.valid && $stable(seq_res.ancestor), "finished item dropped while output was full")

endmodule

[verif/kth_ancestor_checker.sv]
// Scoreboard for tree_kth_ancestor_lookup_core: keeps its own copy of the ancestor
// table and node count, predicts the result of every accepted item and compares.
// Depends on tka_pkg for the op codes and the node width.
`timescale 1ns / 1ps

module kth_ancestor_checker #(
    parameter int MAX_NODES   = 1024,
    parameter int JUMP_LEVELS = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  tka_pkg::op_t               op,
    input  logic [tka_pkg::NODE_W-1:0] node,
    input  logic [tka_pkg::NODE_W-1:0] value,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [tka_pkg::NODE_W-1:0] ancestor,
    input  logic                       is_answer,
    input  logic                       cfg_wr_en,
    input  logic [tka_pkg::NODE_W-1:0] cfg_wr_data,
    output int                         mismatch_count,
    output int                         pending
);
    import tka_pkg::*;

    typedef logic [NODE_W-1:0] node_id_t;

    typedef struct packed {
        node_id_t ancestor;
        logic     is_answer;
    } lookup_result_t;

    localparam node_id_t NODE_COUNT_AT_RESET = 10'd1023;

    node_id_t       jump_tbl [MAX_NODES][JUMP_LEVELS];
    node_id_t       node_count_mirror;
    lookup_result_t expected_results [$];

    // Index of the highest set bit; zero for zero and one.
    function automatic int msb_index(input int x);
        int b;
        b = 0;
        while (x > 1)
        begin
            x = x >> 1;
            b++;
        end
        return b;
    endfunction

    // Table read; out-of-range nodes and levels read as no node.
    function automatic node_id_t jump_of(input int n, input int lvl);
        if (n >= MAX_NODES || lvl >= JUMP_LEVELS)
        begin
            return '0;
        end
        return jump_tbl[n][lvl];
    endfunction

    // Apply one item to the mirrored table and work out the result it gives.
    task automatic apply_item(input op_t item_op, input node_id_t item_node,
                              input node_id_t item_value, output lookup_result_t res);
        int top;
        int last;
        int cur;
        int k;
        int b;
        res = '0;
        case (item_op)
            OP_SET_PARENT:
            begin
                // Node 0 stays a fixed point of every jump.
                if (item_node != 0 && item_node < MAX_NODES)
                begin
                    jump_tbl[item_node][0] = item_value;
                end
            end
            OP_BUILD:
            begin
                if (node_count_mirror != 0)
                begin
                    top = msb_index(node_count_mirror);
                    if (top > JUMP_LEVELS - 1)
                    begin
                        top = JUMP_LEVELS - 1;
                    end
                    last = node_count_mirror;
                    if (last > MAX_NODES - 1)
                    begin
                        last = MAX_NODES - 1;
                    end
                    for (int lvl = 1; lvl <= top; lvl++)
                    begin
                        for (int n = 1; n <= last; n++)
                        begin
                            jump_tbl[n][lvl] = jump_of(jump_of(n, lvl - 1), lvl - 1);
                        end
                    end
                end
            end
            OP_QUERY:
            begin
                // Walk up one jump per set bit of the distance, highest first.
                cur = (item_node < MAX_NODES) ? int'(item_node) : 0;
                k   = item_value;
                while (k > 0)
                begin
                    b = msb_index(k);
                    if (b > JUMP_LEVELS - 1)
                    begin
                        b = JUMP_LEVELS - 1;
                    end
                    cur = jump_of(cur, b);
                    k   = k - (1 << b);
                end
                res.ancestor  = node_id_t'(cur);
                res.is_answer = 1'b1;
            end
            default:
            begin
            end
        endcase
    endtask

    // Watch both channels and the register port at every rising edge.
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        lookup_result_t want;
        lookup_result_t got;
        if (!rst_n)
        begin
            for (int n = 0; n < MAX_NODES; n++)
            begin
                for (int lvl = 0; lvl < JUMP_LEVELS; lvl++)
                begin
                    jump_tbl[n][lvl] = '0;
                end
            end
            expected_results.delete();
            node_count_mirror = NODE_COUNT_AT_RESET;
            mismatch_count    = 0;
            pending           = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                node_count_mirror = cfg_wr_data;
            end
            if (in_valid && !in_stall)
            begin
                apply_item(op, node, value, want);
                expected_results.insert(expected_results.size(), want);
            end
            if (out_valid && !out_stall)
            begin
                got.ancestor  = ancestor;
                got.is_answer = is_answer;
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected item: expected none, got ancestor %0d is_answer %0d",
                             $time, got.ancestor, got.is_answer);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.ancestor !== want.ancestor)
                    begin
                        mismatch_count++;
                        $display("%0t: ancestor mismatch: expected %0d, got %0d",
                                 $time, want.ancestor, got.ancestor);
                    end
                    if (got.is_answer !== want.is_answer)
                    begin
                        mismatch_count++;
                        $display("%0t: is_answer mismatch: expected %0d, got %0d",
                                 $time, want.is_answer, got.is_answer);
                    end
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

[verif/tb.sv]
// Top of the testbench for tree_kth_ancestor_lookup_core: clock, reset, stimulus,
// random stalls on both channels and the verdict.
// Depends on tka_pkg, the core and kth_ancestor_checker.
`timescale 1ns / 1ps

module tb;
    import tka_pkg::*;

    typedef logic [NODE_W-1:0] node_id_t;

    localparam op_t OP_UNUSED   = 2'd3;
    localparam int  RANDOM_ITEMS = 1300;
    localparam int  LONG_HOLD    = 400;
    localparam int  TAIL_CYCLES  = 64;
    localparam int  CYCLE_LIMIT  = 1000000;

    logic     clk         = 1'b0;
    logic     rst_n       = 1'b0;
    logic     in_valid    = 1'b0;
    logic     in_stall;
    op_t      op          = OP_SET_PARENT;
    node_id_t node        = '0;
    node_id_t value       = '0;
    logic     out_valid;
    logic     out_stall   = 1'b0;
    node_id_t ancestor;
    logic     is_answer;
    logic     cfg_wr_en   = 1'b0;
    node_id_t cfg_wr_data = '0;

    int          mismatch_count;
    int          pending;
    int          items_sent     = 0;
    int          send_burst     = 0;
    int          recv_burst     = 0;
    bit          want_long_hold = 1'b0;
    int unsigned cycle_count    = 0;
    int          tree_nodes [$];

    tree_kth_ancestor_lookup_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .node        (node),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .ancestor    (ancestor),
        .is_answer   (is_answer),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    kth_ancestor_checker ancestor_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .node           (node),
        .value          (value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .ancestor       (ancestor),
        .is_answer      (is_answer),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    always #6 clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** tree_kth_ancestor_lookup_core: FAILED **");
            $finish;
        end
    end

    // Idle cycles before the next item: random, with runs of back-to-back items.
    task automatic draw_gap(inout int burst_left, output int gap);
        if (burst_left > 0)
        begin
            burst_left--;
            gap = 0;
        end
        else if ($urandom_range(0, 15) == 0)
        begin
            burst_left = $urandom_range(20, 60);
            gap        = 0;
        end
        else
        begin
            gap = $urandom_range(0, 19);
        end
    endtask

    // Offer one item and hold it until the core takes it.
    task automatic send_item(input op_t item_op, input node_id_t item_node,
                             input node_id_t item_value);
        int gap;
        draw_gap(send_burst, gap);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        op       <= item_op;
        node     <= item_node;
        value    <= item_value;
        do @(posedge clk); while (in_stall);
        if (item_op != OP_UNUSED)
        begin
            items_sent++;
        end
    endtask

    // Stop offering and wait until every expected item has come back.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic set_node_count(input node_id_t count);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Unused op codes, writes to node 0 and stray parents anywhere in the table.
    task automatic send_noise();
        case ($urandom_range(0, 2))
            0: send_item(OP_UNUSED, node_id_t'($urandom), node_id_t'($urandom));
            1: send_item(OP_SET_PARENT, '0, node_id_t'($urandom));
            default: send_item(OP_SET_PARENT, node_id_t'($urandom_range(1, 1023)),
                               node_id_t'($urandom));
        endcase
    endtask

    // Query from a node of the current tree, now and then from anywhere.
    task automatic send_random_query(input int k_max);
        node_id_t q_node;
        node_id_t q_k;
        if ($urandom_range(0, 7) == 0)
        begin
            q_node = node_id_t'($urandom);
        end
        else
        begin
            q_node = node_id_t'(tree_nodes[$urandom_range(0, tree_nodes.size() - 1)]);
        end
        case ($urandom_range(0, 7))
            0: q_k = node_id_t'($urandom);
            1: q_k = node_id_t'(1 << $urandom_range(0, NODE_W - 1));
            default: q_k = node_id_t'($urandom_range(0, k_max));
        endcase
        send_item(OP_QUERY, q_node, q_k);
    endtask

    // One setting of node_count: grow a tree, build, query, sometimes rewire.
    // A sparse phase uses the full node range with a long random chain.
    task automatic run_tree_phase(input int n_nodes, input bit deep, input bit sparse,
                                  input bit hold_here);
        int child;
        int parent;
        int prev;
        int k_max;
        drain_results();
        set_node_count(node_id_t'(n_nodes));
        tree_nodes.delete();
        prev = 0;
        for (int i = 1; i <= (sparse ? 60 : n_nodes); i++)
        begin
            if (sparse)
            begin
                child  = $urandom_range(1, 1023);
                parent = prev;
                prev   = child;
            end
            else
            begin
                child  = i;
                parent = (deep && $urandom_range(0, 4) != 0) ? i - 1 : $urandom_range(0, i - 1);
            end
            tree_nodes.insert(tree_nodes.size(), child);
            send_item(OP_SET_PARENT, node_id_t'(child), node_id_t'(parent));
            if ($urandom_range(0, 19) == 0)
            begin
                send_noise();
            end
        end
        send_item(OP_BUILD, node_id_t'($urandom), node_id_t'($urandom));
        if (hold_here)
        begin
            want_long_hold = 1'b1;
        end
        k_max = sparse ? 70 : n_nodes + 2;
        repeat (40 + $urandom_range(0, 40))
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                send_noise();
            end
            else
            begin
                send_random_query(k_max);
            end
        end
        // Rewire a few parents, query the stale table, then rebuild and query again.
        if ($urandom_range(0, 1) == 1)
        begin
            repeat (3)
            begin
                child = tree_nodes[$urandom_range(0, tree_nodes.size() - 1)];
                send_item(OP_SET_PARENT, node_id_t'(child),
                          node_id_t'($urandom_range(0, child - 1)));
            end
            repeat (5) send_random_query(k_max);
            send_item(OP_BUILD, node_id_t'($urandom), node_id_t'($urandom));
            repeat (5) send_random_query(k_max);
        end
    endtask

    // Result side: random stalls per item, and one long hold-off on request.
    initial
    begin : result_side
        int gap;
        bit long_hold_done;
        long_hold_done = 1'b0;
        forever
        begin
            draw_gap(recv_burst, gap);
            if (want_long_hold && !long_hold_done)
            begin
                gap            = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (gap > 0)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Stimulus and verdict.
    initial
    begin : stimulus
        int phase;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        set_node_count(10'd1023);

        // Directed: query on an empty table, unused op, node 0, a chain over
        // the high node numbers, a full build, then queries around the depth.
        send_item(OP_QUERY, 10'd5, 10'd1);
        send_item(OP_UNUSED, 10'd1023, 10'd1023);
        send_item(OP_SET_PARENT, 10'd0, 10'd1023);
        send_item(OP_SET_PARENT, 10'd1, 10'd0);
        send_item(OP_SET_PARENT, 10'd512, 10'd1);
        send_item(OP_SET_PARENT, 10'd1023, 10'd512);
        send_item(OP_SET_PARENT, 10'd1022, 10'd1023);
        send_item(OP_SET_PARENT, 10'd682, 10'd1022);
        send_item(OP_SET_PARENT, 10'd341, 10'd682);
        send_item(OP_SET_PARENT, 10'd3, 10'd341);
        send_item(OP_BUILD, 10'd0, 10'd0);
        send_item(OP_QUERY, 10'd3, 10'd0);
        send_item(OP_QUERY, 10'd3, 10'd5);
        send_item(OP_QUERY, 10'd3, 10'd6);
        send_item(OP_QUERY, 10'd3, 10'd7);
        send_item(OP_QUERY, 10'd3, 10'd1023);
        send_item(OP_QUERY, 10'd0, 10'd1023);
        send_item(OP_QUERY, 10'd1022, 10'd2);
        send_item(OP_QUERY, 10'd1023, 10'd1);
        // Parent changed after the build: the walk sees a mixed table.
        send_item(OP_SET_PARENT, 10'd1, 10'd1000);
        send_item(OP_QUERY, 10'd3, 10'd7);
        // A node count of zero builds nothing.
        drain_results();
        set_node_count(10'd0);
        send_item(OP_BUILD, 10'd1023, 10'd1023);
        send_item(OP_QUERY, 10'd3, 10'd7);
        // A node count of one builds no levels; parent above the count is kept.
        drain_results();
        set_node_count(10'd1);
        send_item(OP_SET_PARENT, 10'd1, 10'd5);
        send_item(OP_BUILD, 10'd0, 10'd0);
        send_item(OP_QUERY, 10'd1, 10'd1);

        // Random phases, each pausing until all results are back.
        items_sent = 0;
        phase      = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            phase++;
            if (phase == 5)
            begin
                run_tree_phase(1023, 1'b0, 1'b1, 1'b0);
            end
            else if (phase % 4 == 3)
            begin
                run_tree_phase($urandom_range(60, 120), 1'b1, 1'b0, phase == 3);
            end
            else
            begin
                run_tree_phase($urandom_range(2, 40), 1'b0, 1'b0, 1'b0);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("** tree_kth_ancestor_lookup_core: PASSED **");
        end
        else
        begin
            $display("** tree_kth_ancestor_lookup_core: FAILED **");
        end
        $finish;
    end

endmodule
